FILE: rtl/ktst_pkg.sv
// Shared types and constants for the keyed top-k severity tracker.
// No dependencies.
`default_nettype none
package ktst_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned SEV_W = 48;
  localparam int unsigned TIME_W = 63;
  localparam int unsigned LOC_W = 32;
  localparam int unsigned PID_W = 5;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned STAT_W = 3;

  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_KEPT     = 3'd1;
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STAT_W-1:0] ST_REPLACED = 3'd3;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd4;
  localparam logic [STAT_W-1:0] ST_READ     = 3'd5;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd6;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [PID_W-1:0]  pattern_id;
    logic [KEY_W-1:0]  node_id;
    logic [SEV_W-1:0]  severity;
    logic [TIME_W-1:0] enter_time;
    logic [TIME_W-1:0] exit_time;
    logic [TIME_W-1:0] marker_time;
    logic [LOC_W-1:0]  marker_location;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  entry_count;
    logic [KEY_W-1:0]  out_node_id;
    logic [SEV_W-1:0]  out_severity;
    logic [TIME_W-1:0] out_enter_time;
    logic [TIME_W-1:0] out_exit_time;
    logic [TIME_W-1:0] out_marker_time;
    logic [LOC_W-1:0]  out_marker_location;
  } out_item_t;

  // one stored entry
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SEV_W-1:0]  sev;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
    logic [TIME_W-1:0] t2;
    logic [LOC_W-1:0]  loc;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic rd_req;    // issue memory read at scan index (slot index for a read item)
    logic rd_cap;    // compare data returned by previous read
    logic wr;        // perform write at write index
    logic shift_rd;  // shift pass: read source entry
    logic fin;       // compute result
  } ktst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic shift_done;
  } ktst_sts_t;

endpackage
`default_nettype wire

FILE: rtl/ktst_ctrl.sv
// Sequencer for the tracker: steps the datapath through scan, shift and finish.
// Depends on ktst_pkg.
`default_nettype none
module ktst_ctrl
  import ktst_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire       out_ready,
  input  ktst_sts_t sts_i,
  output ktst_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_SHW   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       ov_q, ov_d;

  // new item may start once the previous result has been taken or is leaving
  assign in_ready  = (state_q == S_IDLE) && (!ov_q || out_ready);
  assign out_valid = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && !out_ready;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_req = 1'b1;
        cmd_o.rd_cap = 1'b1;
        if (sts_i.scan_done) state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHW;
        end
      end
      S_SHW: begin
        cmd_o.wr = 1'b1;
        state_d  = S_SHIFT;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        ov_d      = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ktst_dp.sv
// Tracker datapath: entry memory, fill counts, key scan and sorted shift.
// Depends on ktst_pkg.
`default_nettype none
module ktst_dp
  import ktst_pkg::*;
#(
  parameter int unsigned PATTERNS = 32,
  parameter int unsigned SLOTS    = 8
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       enable_i,
  input  in_item_t  item_i,
  input  ktst_cmd_t cmd_i,
  output ktst_sts_t sts_o,
  output out_item_t res_o
);

  localparam int unsigned SI_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SC_W  = $clog2(SLOTS + 1);
  localparam int unsigned PI_W  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int unsigned ADR_W = PI_W + SI_W;
  localparam int unsigned DEPTH = PATTERNS * (2 ** SI_W);

  entry_t mem [DEPTH];

  logic [SC_W-1:0] fill_q [PATTERNS];

  in_item_t        it_q;
  logic            pid_ok_q;
  logic [PI_W-1:0] pid_q;
  logic [SC_W-1:0] n_q;

  // scan state
  logic [SC_W-1:0] ridx_q;      // next address issued
  logic            rv_q;        // read data valid
  logic [SC_W-1:0] cidx_q;      // index of rd data
  entry_t          rdata_q;
  logic            found_q;
  logic [SC_W-1:0] r_q;
  logic [SEV_W-1:0] rsev_q;
  logic [SEV_W-1:0] min_q;
  logic [SC_W-1:0] pos_q;       // count of entries with sev <= new
  logic            scan_done_q;

  // shift plan
  logic            act_q;       // a write happens
  logic [SC_W-1:0] dst_q;       // final insertion position
  logic [SC_W-1:0] sh_q;        // current shift step position
  logic            sh_done_q;
  logic [STAT_W-1:0] stat_q;
  logic [SC_W-1:0] nn_q;
  logic [SC_W-1:0] sidx_q;

  // planning in the cycle after the last scan step (all counters settled)
  logic              plan_now, planned_q;
  logic              plan_act;
  logic [STAT_W-1:0] plan_stat;
  logic [SC_W-1:0]   plan_nn, plan_sidx, plan_rem, plan_dst;

  logic [SC_W-1:0] raddr;
  logic            is_read;
  logic            wr_new;
  logic [SC_W-1:0] pos_d;
  logic            scan_last;
  logic [SC_W-1:0] eff_pos;

  out_item_t res_q, res_d;

  entry_t newe;
  assign newe = '{key: it_q.node_id, sev: it_q.severity, t0: it_q.enter_time,
                  t1: it_q.exit_time, t2: it_q.marker_time, loc: it_q.marker_location};

  function automatic logic [ADR_W-1:0] adr(input logic [PI_W-1:0] p,
                                           input logic [SC_W-1:0] s);
    adr = {p, s[SI_W-1:0]};
  endfunction

  // read port address
  assign is_read = (it_q.kind == KIND_READ);
  always_comb begin
    if (cmd_i.shift_rd) raddr = (sh_q > dst_q) ? sh_q - SC_W'(1) : sh_q + SC_W'(1);
    else if (is_read)   raddr = SC_W'(it_q.slot);
    else                raddr = ridx_q;
  end

  // shift write: when sh != dst move neighbor into sh, else place new entry
  assign wr_new = (sh_q == dst_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_req || cmd_i.shift_rd) rdata_q <= mem[adr(pid_q, raddr)];
    if (cmd_i.wr) mem[adr(pid_q, sh_q)] <= wr_new ? newe : rdata_q;
  end

  // scan through entries; scan ends once the registered read data of the last stored entry is back
  assign scan_last = is_read ? rv_q : (rv_q && (cidx_q + SC_W'(1) >= n_q)) || n_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PATTERNS; i++) fill_q[i] <= '0;
      rv_q        <= 1'b0;
      scan_done_q <= 1'b0;
      sh_done_q   <= 1'b0;
      act_q       <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rv_q        <= 1'b0;
        scan_done_q <= 1'b0;
      end else if (cmd_i.rd_cap && !scan_done_q) begin
        rv_q <= 1'b1;
        if (scan_last) scan_done_q <= 1'b1;
      end
      if (cmd_i.load) begin
        act_q <= 1'b0;
      end else if (plan_now) begin
        act_q     <= plan_act;
        sh_done_q <= !plan_act;
      end else if (cmd_i.wr && wr_new) begin
        sh_done_q <= 1'b1;
      end
      if (cmd_i.fin && act_q) fill_q[pid_q] <= nn_q;
    end
  end

  // comparison of the returned entry during the scan
  always_comb begin
    pos_d = pos_q;
    if (rv_q && !is_read && cidx_q < n_q) begin
      if (rdata_q.sev <= it_q.severity) pos_d = pos_q + SC_W'(1);
    end
  end

  // count of entries with sev <= new that are not the removed one
  // removed entry: found key (update) or slot 0 (replace min)
  always_comb begin
    eff_pos = pos_q;
    if (found_q) begin
      if (rsev_q <= it_q.severity) eff_pos = pos_q - SC_W'(1);
    end else if (n_q == SC_W'(SLOTS)) begin
      if (min_q <= it_q.severity) eff_pos = pos_q - SC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q     <= item_i;
      pid_ok_q <= (32'(item_i.pattern_id) < PATTERNS);
      pid_q    <= PI_W'(item_i.pattern_id);
      n_q      <= (32'(item_i.pattern_id) < PATTERNS) ? fill_q[PI_W'(item_i.pattern_id)] : '0;
      ridx_q   <= '0;
      cidx_q   <= '0;
      found_q  <= 1'b0;
      pos_q    <= '0;
      r_q      <= '0;
      rsev_q   <= '0;
    end else if (cmd_i.rd_cap && !scan_done_q) begin
      ridx_q <= ridx_q + SC_W'(1);
      if (rv_q) begin
        cidx_q <= cidx_q + SC_W'(1);
        pos_q  <= pos_d;
        if (cidx_q == '0) min_q <= rdata_q.sev;
        if (!is_read && cidx_q < n_q && !found_q && rdata_q.key == it_q.node_id) begin
          found_q <= 1'b1;
          r_q     <= cidx_q;
          rsev_q  <= rdata_q.sev;
        end
      end
    end
    if (cmd_i.wr && !wr_new) sh_q <= (sh_q > dst_q) ? sh_q - SC_W'(1) : sh_q + SC_W'(1);
    if (plan_now) begin
      stat_q <= plan_stat;
      nn_q   <= plan_nn;
      sidx_q <= plan_sidx;
      dst_q  <= plan_dst;
      sh_q   <= plan_rem;
    end
  end

  assign plan_now = scan_done_q && !planned_q && !is_read;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              planned_q <= 1'b0;
    else if (cmd_i.load)      planned_q <= 1'b0;
    else if (plan_now)        planned_q <= 1'b1;
  end

  always_comb begin
    plan_act  = 1'b0;
    plan_stat = ST_DROPPED;
    plan_nn   = n_q;
    plan_sidx = '0;
    plan_rem  = '0;
    plan_dst  = eff_pos;
    if (!pid_ok_q) begin
      plan_stat = ST_DROPPED;
      plan_nn   = '0;
    end else if (!enable_i) begin
      plan_stat = ST_EMPTY;
    end else if (found_q) begin
      if (rsev_q < it_q.severity) begin
        plan_stat = ST_UPDATED; plan_rem = r_q; plan_sidx = eff_pos; plan_act = 1'b1;
      end else begin
        plan_stat = ST_KEPT; plan_sidx = r_q;
      end
    end else if (n_q < SC_W'(SLOTS)) begin
      plan_stat = ST_INSERTED; plan_rem = n_q; plan_sidx = pos_q;
      plan_dst  = pos_q; plan_nn = n_q + SC_W'(1); plan_act = 1'b1;
    end else if (n_q != '0 && it_q.severity > min_q) begin
      plan_stat = ST_REPLACED; plan_rem = '0; plan_sidx = eff_pos; plan_act = 1'b1;
    end
  end

  // controller waits in shift until plan is taken
  assign sts_o.scan_done  = scan_done_q;
  assign sts_o.shift_done = is_read || (planned_q && sh_done_q);

  // result
  always_comb begin
    res_d = '0;
    if (is_read) begin
      res_d.slot_index  = it_q.slot;
      res_d.entry_count = CNT_W'(n_q);
      if (!pid_ok_q) begin
        res_d.status     = ST_EMPTY;
        res_d.slot_index = '0;
      end else if (SC_W'(it_q.slot) < n_q && 32'(it_q.slot) < SLOTS) begin
        res_d.status              = ST_READ;
        res_d.out_node_id         = rdata_q.key;
        res_d.out_severity        = rdata_q.sev;
        res_d.out_enter_time      = rdata_q.t0;
        res_d.out_exit_time       = rdata_q.t1;
        res_d.out_marker_time     = rdata_q.t2;
        res_d.out_marker_location = rdata_q.loc;
      end else begin
        res_d.status = ST_EMPTY;
      end
    end else begin
      res_d.status      = stat_q;
      res_d.slot_index  = SLOT_W'(sidx_q);
      res_d.entry_count = CNT_W'(nn_q);
    end
  end

  assign res_o = res_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) res_q <= res_d;
  end

endmodule
`default_nettype wire

FILE: rtl/keyed_top_k_severity_tracker_core.sv
// Top level of the keyed top-k severity tracker: controller, datapath, enable register.
// Depends on ktst_pkg, ktst_ctrl, ktst_dp.
// An add runs through a key scan (one memory read per stored entry of the addressed
// table, each compared once its registered read data returns), a planning step, a shift
// loop that reads and then writes each moved entry and finally writes the new one through
// the single-port entry memory, an exit from the shift loop and a step that forms the
// result. Kept, dropped and disabled adds write nothing and leave the shift loop at once.
// A read fetches its one addressed entry and then forms the result. One item at a time;
// the next is accepted at the earliest together with the result transfer, which can be in
// the cycle the result appears. The enable register is written through cfg_valid/cfg_ready
// and should only change idle.
`default_nettype none
module keyed_top_k_severity_tracker_core
  import ktst_pkg::*;
#(
  parameter int unsigned PATTERNS = 32,
  parameter int unsigned SLOTS    = 8
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid,
  output logic      in_ready,
  input  in_item_t  in_data_i,
  output logic      out_valid,
  input  wire       out_ready,
  output out_item_t out_data_o,
  input  wire       cfg_valid,
  output logic      cfg_ready,
  input  wire       cfg_data_i
);

  logic      enable_q;
  ktst_cmd_t cmd;
  ktst_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)        enable_q <= 1'b1;
    else if (cfg_valid) enable_q <= cfg_data_i;
  end

  ktst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ktst_dp #(.PATTERNS(PATTERNS), .SLOTS(SLOTS)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enable_i (enable_q),
    .item_i   (in_data_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .res_o    (out_data_o)
  );

endmodule
`default_nettype wire

FILE: rtl/ktst_checker.sv
// Port-level checks for the tracker top level, attached by bind.
// Depends on ktst_pkg.
`default_nettype none
module ktst_checker
  import ktst_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data_o))
    else $error("result dropped while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken during work");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data_o.status != ST_READ |-> out_data_o.out_node_id == '0)
    else $error("payload set on non-read result");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> 32'(out_data_o.entry_count) <= SLOTS)
    else $error("count out of range");

endmodule

bind keyed_top_k_severity_tracker_core ktst_checker #(.SLOTS(SLOTS)) u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_data_o (out_data_o)
);
`default_nettype wire
